@@ rtl/core/u8dec_pkg.sv @@
`timescale 1ns / 1ps

package u8dec_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [20:0] scalar_val;
    logic [2:0]  seq_length;
    logic [2:0]  error_kind;
  } out_item_t;

  typedef enum logic [2:0] {
    CLS_ASCII   = 3'd0,
    CLS_LEAD2   = 3'd1,
    CLS_LEAD3   = 3'd2,
    CLS_LEAD4   = 3'd3,
    CLS_CONT    = 3'd4,
    CLS_INVALID = 3'd5
  } byte_class_t;

  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_BAD_LEAD = 3'd1,
    ERR_BAD_CONT = 3'd2,
    ERR_RANGE    = 3'd3,
    ERR_TRUNC    = 3'd4
  } err_kind_t;

  // classified byte handed from front to back
  typedef struct packed {
    byte_class_t cls;
    logic [6:0]  bits;
    logic        eos;
  } cls_item_t;

  localparam logic [20:0] MAX_SCALAR     = 21'h10FFFF;
  localparam logic [20:0] SURR_LO        = 21'h00D800;
  localparam logic [20:0] SURR_HI        = 21'h00DFFF;
  localparam logic [20:0] MIN_THREE_BYTE = 21'h000800;
  localparam logic [20:0] MIN_FOUR_BYTE  = 21'h010000;

endpackage

@@ rtl/core/u8dec_front.sv @@
`timescale 1ns / 1ps

module u8dec_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  u8dec_pkg::in_item_t  in_data,
  output logic                 q_valid,
  output u8dec_pkg::cls_item_t q_item,
  input  logic                 q_take
);
  import u8dec_pkg::*;

  cls_item_t  cls_item;
  cls_item_t  mem_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic       do_push, do_pop;

  always_comb begin
    cls_item.eos  = in_data.end_of_stream;
    cls_item.bits = 7'd0;
    cls_item.cls  = CLS_INVALID;
    priority if (in_data.in_byte[7] == 1'b0) begin
      cls_item.cls  = CLS_ASCII;
      cls_item.bits = in_data.in_byte[6:0];
    end else if (in_data.in_byte[7:6] == 2'b10) begin
      cls_item.cls  = CLS_CONT;
      cls_item.bits = {1'b0, in_data.in_byte[5:0]};
    end else if (in_data.in_byte >= 8'hC2 && in_data.in_byte <= 8'hDF) begin
      cls_item.cls  = CLS_LEAD2;
      cls_item.bits = {2'b00, in_data.in_byte[4:0]};
    end else if (in_data.in_byte[7:4] == 4'hE) begin
      cls_item.cls  = CLS_LEAD3;
      cls_item.bits = {3'b000, in_data.in_byte[3:0]};
    end else if (in_data.in_byte >= 8'hF0 && in_data.in_byte <= 8'hF4) begin
      cls_item.cls  = CLS_LEAD4;
      cls_item.bits = {4'b0000, in_data.in_byte[2:0]};
    end else begin
      cls_item.cls  = CLS_INVALID;
    end
  end

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = q_valid && q_take;

  always_comb begin
    cnt_nxt    = cnt_r;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (do_pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= cls_item;
    end
  end

endmodule

@@ rtl/core/u8dec_back.sv @@
`timescale 1ns / 1ps

module u8dec_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  u8dec_pkg::cls_item_t q_item,
  output logic                 q_take,
  output logic                 empty,
  input  logic                 pop,
  output u8dec_pkg::out_item_t out_data
);
  import u8dec_pkg::*;

  logic [1:0]  rem_r, rem_nxt;
  logic [2:0]  total_r, total_nxt;
  logic [20:0] acc_r, acc_nxt;
  logic [20:0] shifted;
  logic [2:0]  taken;
  logic        emit;
  out_item_t   res;

  out_item_t   res_mem_r [2];
  logic [1:0]  res_cnt_r, res_cnt_nxt;
  logic        res_wr_r, res_rd_r;
  logic        res_push, res_pop;

  assign q_take  = q_valid && (res_cnt_r != 2'd2);
  assign shifted = {acc_r[14:0], q_item.bits[5:0]};
  assign taken   = total_r - {1'b0, rem_r} + 3'd1;

  always_comb begin
    rem_nxt   = rem_r;
    total_nxt = total_r;
    acc_nxt   = acc_r;
    emit      = 1'b0;
    res       = '{scalar_val: 21'd0, seq_length: 3'd1, error_kind: ERR_OK};
    if (q_take) begin
      if (rem_r == 2'd0) begin
        unique case (q_item.cls)
          CLS_ASCII: begin
            emit           = 1'b1;
            res.scalar_val = {14'd0, q_item.bits};
          end
          CLS_LEAD2, CLS_LEAD3, CLS_LEAD4: begin
            if (q_item.eos) begin
              emit           = 1'b1;
              res.error_kind = ERR_TRUNC;
            end else begin
              acc_nxt = {14'd0, q_item.bits};
              unique case (q_item.cls)
                CLS_LEAD2: begin total_nxt = 3'd2; rem_nxt = 2'd1; end
                CLS_LEAD3: begin total_nxt = 3'd3; rem_nxt = 2'd2; end
                default:   begin total_nxt = 3'd4; rem_nxt = 2'd3; end
              endcase
            end
          end
          default: begin
            emit           = 1'b1;
            res.error_kind = ERR_BAD_LEAD;
          end
        endcase
      end else begin
        priority if (q_item.eos && rem_r > 2'd1) begin
          emit           = 1'b1;
          res.seq_length = taken;
          res.error_kind = ERR_TRUNC;
        end else if (q_item.cls != CLS_CONT) begin
          emit           = 1'b1;
          res.seq_length = taken;
          res.error_kind = ERR_BAD_CONT;
        end else if (rem_r != 2'd1) begin
          acc_nxt = shifted;
          rem_nxt = rem_r - 2'd1;
        end else begin
          // last continuation byte: range and surrogate checks
          emit           = 1'b1;
          res.seq_length = total_r;
          if ((total_r == 3'd3 && shifted < MIN_THREE_BYTE) ||
              (total_r == 3'd4 && shifted < MIN_FOUR_BYTE) ||
              shifted > MAX_SCALAR ||
              (shifted >= SURR_LO && shifted <= SURR_HI)) begin
            res.error_kind = ERR_RANGE;
          end else begin
            res.scalar_val = shifted;
          end
        end
      end
      if (emit) begin
        rem_nxt   = 2'd0;
        total_nxt = 3'd0;
        acc_nxt   = 21'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r   <= 2'd0;
      total_r <= 3'd0;
      acc_r   <= 21'd0;
    end else begin
      rem_r   <= rem_nxt;
      total_r <= total_nxt;
      acc_r   <= acc_nxt;
    end
  end

  // result queue
  assign res_push = emit;
  assign empty    = (res_cnt_r == 2'd0);
  assign res_pop  = pop && !empty;
  assign out_data = res_mem_r[res_rd_r];

  always_comb begin
    unique case ({res_push, res_pop})
      2'b10:   res_cnt_nxt = res_cnt_r + 2'd1;
      2'b01:   res_cnt_nxt = res_cnt_r - 2'd1;
      default: res_cnt_nxt = res_cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_cnt_r <= 2'd0;
      res_wr_r  <= 1'b0;
      res_rd_r  <= 1'b0;
    end else begin
      res_cnt_r <= res_cnt_nxt;
      if (res_push) begin
        res_wr_r <= ~res_wr_r;
      end
      if (res_pop) begin
        res_rd_r <= ~res_rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_mem_r[res_wr_r] <= res;
    end
  end

endmodule

@@ rtl/core/utf8_stream_decoder.sv @@
`timescale 1ns / 1ps
// utf8_stream_decoder: validating utf-8 decoder, one byte per transaction.
// input side is a queue: drive in_data (byte plus end-of-stream flag) and
// push; a transaction completes on a clock edge with push high and full low.
// result side is a queue too: while empty is low out_data holds the oldest
// result (code point, sequence length, error kind); raise pop to take it.
// each byte gives zero or one result: ascii bytes, final continuation bytes
// and every error give one, other lead and continuation bytes give none.
// a byte is classified by the front stage and written into a two-entry
// queue; the back stage takes one classified byte per cycle while the
// result queue has room and updates the sequence state; each result goes
// into the result queue as the back stage takes the byte that caused it.
// throughput is one byte per clock while results drain, set by the
// back stage. when the receiver stalls, the two-entry result queue fills,
// then the byte queue, then full rises; nothing is lost.
// synchronous reset empties both queues and leaves the decoder idle,
// waiting for a lead byte.
module utf8_stream_decoder (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  u8dec_pkg::in_item_t  in_data,
  output logic                 empty,
  input  logic                 pop,
  output u8dec_pkg::out_item_t out_data
);
  import u8dec_pkg::*;

  cls_item_t q_item;
  logic      q_valid;
  logic      q_take;

  u8dec_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_take  (q_take)
  );

  u8dec_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_take   (q_take),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule
